[hdl/euler_to_rotation_matrix_unit_defines.svh]
// Assertion macros shared by the rotation matrix unit.
// Depends on nothing; included by the files that carry assertions.
`ifndef EULER_TO_ROTATION_MATRIX_UNIT_DEFINES_SVH
`define EULER_TO_ROTATION_MATRIX_UNIT_DEFINES_SVH

// Condition implies consequence in the same cycle, outside of reset.
`define ETRM_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle, outside of reset.
`define ETRM_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

// Condition implies consequence in the next cycle, checked during reset too.
`define ETRM_ASSERT_NEXT_ANY(label, clk, cond, cons, msg) \
   label: assert property (@(posedge clk) (cond) |=> (cons)) else $error(msg);

`endif

[hdl/etrm_pkg.sv]
// Types, constants and helper functions of the rotation matrix unit.
// Depends on nothing.
package etrm_pkg;

   localparam int CordicSteps = 30;
   localparam int IntFrac     = 30;
   localparam int QW          = 33;
   localparam logic signed [QW-1:0] CordicGainInit = 33'sd652032874;

   typedef logic signed [QW-1:0] q_type;

   typedef struct packed {
      logic signed [15:0] yaw_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] m00;
      logic signed [15:0] m10;
      logic signed [15:0] m20;
      logic signed [15:0] m01;
      logic signed [15:0] m11;
      logic signed [15:0] m21;
      logic signed [15:0] m02;
      logic signed [15:0] m12;
      logic signed [15:0] m22;
   } rsp_type;

   typedef struct packed {
      q_type x;
      q_type y;
      q_type z;
      logic  flip;
   } lane_type;

   typedef struct packed {
      logic           valid;
      lane_type [2:0] lane;
   } cell_type;

   function automatic q_type atan_value(input int step);
      case (step)
         0: atan_value = 33'sd536870912;
         1: atan_value = 33'sd316933406;
         2: atan_value = 33'sd167458907;
         3: atan_value = 33'sd85004756;
         4: atan_value = 33'sd42667331;
         5: atan_value = 33'sd21354465;
         6: atan_value = 33'sd10679838;
         7: atan_value = 33'sd5340245;
         8: atan_value = 33'sd2670163;
         9: atan_value = 33'sd1335087;
         10: atan_value = 33'sd667544;
         11: atan_value = 33'sd333772;
         12: atan_value = 33'sd166886;
         13: atan_value = 33'sd83443;
         14: atan_value = 33'sd41721;
         15: atan_value = 33'sd20861;
         16: atan_value = 33'sd10430;
         17: atan_value = 33'sd5215;
         18: atan_value = 33'sd2608;
         19: atan_value = 33'sd1304;
         20: atan_value = 33'sd652;
         21: atan_value = 33'sd326;
         22: atan_value = 33'sd163;
         23: atan_value = 33'sd81;
         24: atan_value = 33'sd41;
         25: atan_value = 33'sd20;
         26: atan_value = 33'sd10;
         27: atan_value = 33'sd5;
         28: atan_value = 33'sd3;
         29: atan_value = 33'sd1;
         default: atan_value = '0;
      endcase
   endfunction

   // Product of two Q3.30 values, rounded half up back to Q3.30.
   function automatic q_type mul30(input q_type a, input q_type b);
      logic signed [2*QW-1:0] p;
      logic signed [2*QW-1:0] r;
      p = a * b;
      r = (p + (66'sd1 <<< (IntFrac - 1))) >>> IntFrac;
      mul30 = r[QW-1:0];
   endfunction

endpackage

[hdl/etrm_cordic_cell.sv]
// One rotation step of the sine and cosine chain, for all three angles.
// Depends on etrm_pkg.
module etrm_cordic_cell
   import etrm_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  cell_type cell_in,
   output cell_type cell_out
);

   logic           valid_ff;
   lane_type [2:0] lane_ff;
   lane_type [2:0] lane_in;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lane_in[k].flip = cell_in.lane[k].flip;
         if (!cell_in.lane[k].z[QW-1]) begin
            lane_in[k].x = cell_in.lane[k].x - (cell_in.lane[k].y >>> STEP);
            lane_in[k].y = cell_in.lane[k].y + (cell_in.lane[k].x >>> STEP);
            lane_in[k].z = cell_in.lane[k].z - atan_value(STEP);
         end else begin
            lane_in[k].x = cell_in.lane[k].x + (cell_in.lane[k].y >>> STEP);
            lane_in[k].y = cell_in.lane[k].y - (cell_in.lane[k].x >>> STEP);
            lane_in[k].z = cell_in.lane[k].z + atan_value(STEP);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign cell_out.valid = valid_ff;
   assign cell_out.lane  = lane_ff;

endmodule

[hdl/etrm_matrix.sv]
// Products of sines and cosines, sums, rounding and clamping of the nine entries.
// Depends on etrm_pkg.
module etrm_matrix
   import etrm_pkg::*;
#(
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  cell_type cell_in,
   output logic     rsp_valid,
   output rsp_type  rsp_data
);

   localparam int Sh = IntFrac - COEF_FRAC_BITS;
   localparam logic signed [39:0] Rnd = (Sh > 0) ? (40'sd1 <<< (Sh - 1)) : 40'sd0;
   localparam logic signed [39:0] Lim = 40'sd1 <<< COEF_FRAC_BITS;

   q_type sy, cy, sp, cp, sr, cr;

   logic  v1_ff, v2_ff, out_valid_ff;
   q_type cysp_ff, sysp_ff, cycp_ff, sycp_ff, sycr_ff, cycr_ff, cpsr_ff;
   q_type sysr_ff, cysr_ff, cpcr_ff, sp1_ff, sr1_ff, cr1_ff;
   q_type a_ff, b_ff, c_ff, d_ff;
   q_type cycp2_ff, sycp2_ff, sp2_ff, sycr2_ff, cycr2_ff, cpsr2_ff;
   q_type sysr2_ff, cysr2_ff, cpcr2_ff;
   rsp_type rsp_ff, rsp_in;

   function automatic logic signed [15:0] finish(input logic signed [QW:0] v);
      logic signed [39:0] r;
      r = (40'(v) + Rnd) >>> Sh;
      if (r > Lim) r = Lim;
      if (r < -Lim) r = -Lim;
      finish = r[15:0];
   endfunction

   // Second and third quadrant angles come out of the chain negated.
   always_comb begin
      sy = cell_in.lane[0].flip ? -cell_in.lane[0].y : cell_in.lane[0].y;
      cy = cell_in.lane[0].flip ? -cell_in.lane[0].x : cell_in.lane[0].x;
      sp = cell_in.lane[1].flip ? -cell_in.lane[1].y : cell_in.lane[1].y;
      cp = cell_in.lane[1].flip ? -cell_in.lane[1].x : cell_in.lane[1].x;
      sr = cell_in.lane[2].flip ? -cell_in.lane[2].y : cell_in.lane[2].y;
      cr = cell_in.lane[2].flip ? -cell_in.lane[2].x : cell_in.lane[2].x;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= cell_in.valid;
         v2_ff        <= v1_ff;
         out_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cysp_ff  <= mul30(cy, sp);
         sysp_ff  <= mul30(sy, sp);
         cycp_ff  <= mul30(cy, cp);
         sycp_ff  <= mul30(sy, cp);
         sycr_ff  <= mul30(sy, cr);
         cycr_ff  <= mul30(cy, cr);
         cpsr_ff  <= mul30(cp, sr);
         sysr_ff  <= mul30(sy, sr);
         cysr_ff  <= mul30(cy, sr);
         cpcr_ff  <= mul30(cp, cr);
         sp1_ff   <= sp;
         sr1_ff   <= sr;
         cr1_ff   <= cr;

         a_ff     <= mul30(cysp_ff, sr1_ff);
         b_ff     <= mul30(sysp_ff, sr1_ff);
         c_ff     <= mul30(cysp_ff, cr1_ff);
         d_ff     <= mul30(sysp_ff, cr1_ff);
         cycp2_ff <= cycp_ff;
         sycp2_ff <= sycp_ff;
         sp2_ff   <= sp1_ff;
         sycr2_ff <= sycr_ff;
         cycr2_ff <= cycr_ff;
         cpsr2_ff <= cpsr_ff;
         sysr2_ff <= sysr_ff;
         cysr2_ff <= cysr_ff;
         cpcr2_ff <= cpcr_ff;

         rsp_ff   <= rsp_in;
      end
   end

   always_comb begin
      rsp_in.m00 = finish(34'(cycp2_ff));
      rsp_in.m10 = finish(34'(sycp2_ff));
      rsp_in.m20 = finish(-34'(sp2_ff));
      rsp_in.m01 = finish(34'(a_ff) - 34'(sycr2_ff));
      rsp_in.m11 = finish(34'(b_ff) + 34'(cycr2_ff));
      rsp_in.m21 = finish(34'(cpsr2_ff));
      rsp_in.m02 = finish(34'(c_ff) + 34'(sysr2_ff));
      rsp_in.m12 = finish(34'(d_ff) - 34'(cysr2_ff));
      rsp_in.m22 = finish(34'(cpcr2_ff));
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hdl/euler_to_rotation_matrix_unit.sv]
// Top level of the Z-Y-X Euler angle to rotation matrix unit.
// Depends on etrm_pkg, etrm_cordic_cell, etrm_matrix and the defines header.
//
// Takes one item of yaw, pitch and roll binary angles per cycle and returns
// the nine Q2.14 matrix entries: a chain of rotation cells yields all six
// sines and cosines, then come two multiply stages and one sum, rounding and
// clamping stage. The whole pipeline holds when a result waits at the output,
// so the sustained rate is one item per cycle whenever the output is taken.
`include "euler_to_rotation_matrix_unit_defines.svh"

module euler_to_rotation_matrix_unit
   import etrm_pkg::*;
#(
   parameter int ANGLE_WIDTH    = 16,
   parameter int COEF_FRAC_BITS = 14
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic     advance;
   cell_type chain [0:CordicSteps];
   logic [15:0] angle [0:2];

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign angle[0] = req_data.yaw_angle;
   assign angle[1] = req_data.pitch_angle;
   assign angle[2] = req_data.roll_angle;

   // Angles in the second and third quadrant are turned by half a circle.
   always_comb begin
      logic [63:0] masked;
      logic [31:0] ph;
      chain[0].valid = req_valid;
      for (int k = 0; k < 3; k++) begin
         masked = {48'd0, angle[k]} & ((64'd1 << ANGLE_WIDTH) - 64'd1);
         ph = masked[31:0] << (32 - ANGLE_WIDTH);
         chain[0].lane[k].flip = ph[31] ^ ph[30];
         if (ph[31] ^ ph[30]) begin
            ph[31] = ~ph[31];
         end
         chain[0].lane[k].x = CordicGainInit;
         chain[0].lane[k].y = '0;
         chain[0].lane[k].z = {ph[31], ph};
      end
   end

   for (genvar i = 0; i < CordicSteps; i++) begin : g_cell
      etrm_cordic_cell #(
         .STEP(i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .cell_in (chain[i]),
         .cell_out(chain[i+1])
      );
   end

   etrm_matrix #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_matrix (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .cell_in  (chain[CordicSteps]),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   `ETRM_ASSERT_SAME(a_ready_follows_output, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready), "ready does not follow the output stage")
   `ETRM_ASSERT_NEXT(a_stall_holds_chain, clock, reset, !advance, $stable(chain[1].valid) && $stable(chain[CordicSteps].valid), "chain moved during a stall")
   `ETRM_ASSERT_NEXT(a_accept_enters_chain, clock, reset, req_valid && req_ready, chain[1].valid, "accepted item did not enter the chain")
   `ETRM_ASSERT_NEXT_ANY(a_reset_empties_output, clock, reset, !rsp_valid && !chain[1].valid, "reset left items in flight")

endmodule

[dv/testbench.sv]
// Testbench of the Euler angle to rotation matrix unit: directed and random
// angle triples, checked against a built-in CORDIC matrix predictor.
// Depends on etrm_pkg and euler_to_rotation_matrix_unit.
`timescale 1ns / 100ps

module testbench;
   import etrm_pkg::*;

   localparam int HoldOffCycles = 200;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type matrix_queue[$];
   int      error_count = 0;
   bit      hold_off = 1'b0;
   bit      gaps_on = 1'b1;

   euler_to_rotation_matrix_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #1 clock = ~clock;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint mul_q30(longint a, longint b);
      return floor_shift(a * b + (64'sd1 <<< 29), 30);
   endfunction

   function automatic void sin_cos(input logic [15:0] angle, output longint sn,
                                   output longint cs);
      longint atan_steps[30] = '{536870912, 316933406, 167458907, 85004756,
         42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
         333772, 166886, 83443, 41721, 20861, 10430, 5215, 2608, 1304, 652,
         326, 163, 81, 41, 20, 10, 5, 3, 1};
      logic [31:0] phase;
      bit          flip;
      longint      x, y, z, dx, dy;
      phase = {angle, 16'h0000};
      flip = (phase[31:30] == 2'b01) || (phase[31:30] == 2'b10);
      if (flip) begin
         phase = phase + 32'h8000_0000;
      end
      z = longint'($signed(phase));
      x = 652032874;
      y = 0;
      for (int i = 0; i < 30; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_steps[i];
         end else begin
            x += dx; y -= dy; z += atan_steps[i];
         end
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
   endfunction

   function automatic logic [15:0] to_q14(longint v);
      longint r;
      r = floor_shift(v + (64'sd1 <<< 15), 16);
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return r[15:0];
   endfunction

   function automatic rsp_type rotation_matrix(req_type a);
      longint sy, cy, sp, cp, sr, cr, cysp, sysp;
      rsp_type m;
      sin_cos(a.yaw_angle, sy, cy);
      sin_cos(a.pitch_angle, sp, cp);
      sin_cos(a.roll_angle, sr, cr);
      cysp = mul_q30(cy, sp);
      sysp = mul_q30(sy, sp);
      m.m00 = to_q14(mul_q30(cy, cp));
      m.m10 = to_q14(mul_q30(sy, cp));
      m.m20 = to_q14(-sp);
      m.m01 = to_q14(mul_q30(cysp, sr) - mul_q30(sy, cr));
      m.m11 = to_q14(mul_q30(sysp, sr) + mul_q30(cy, cr));
      m.m21 = to_q14(mul_q30(cp, sr));
      m.m02 = to_q14(mul_q30(cysp, cr) + mul_q30(sy, sr));
      m.m12 = to_q14(mul_q30(sysp, cr) - mul_q30(cy, sr));
      m.m22 = to_q14(mul_q30(cp, cr));
      return m;
   endfunction

   // Sends one item; valid stays high across back-to-back items.
   task automatic send_angles(req_type a);
      req_valid <= 1'b1;
      req_data  <= a;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      matrix_queue.push_back(rotation_matrix(a));
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_corner_angles();
      logic [15:0] corners[10] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
         16'h7FFF, 16'h8001, 16'h3FFF, 16'h4001, 16'hBFFF, 16'hFFFF};
      for (int i = 0; i < 10; i++) begin
         send_angles('{corners[i], corners[(i + 3) % 10], corners[(i + 7) % 10]});
      end
      send_angles('{16'h2000, 16'h4000, 16'hE000});   // gimbal lock, pitch 90
      send_angles('{16'h6000, 16'hC000, 16'h1000});   // gimbal lock, pitch -90
      send_angles('{16'hFFFF, 16'hFFFF, 16'hFFFF});
      send_angles('{16'h5555, 16'hAAAA, 16'h5555});
      send_angles('{16'hAAAA, 16'h5555, 16'hAAAA});
      idle_sender();
   endtask

   task automatic test_random_angles(int count);
      for (int i = 0; i < count; i++) begin
         send_angles('{16'($urandom), 16'($urandom), 16'($urandom)});
      end
      idle_sender();
   endtask

   // The receiver stops for a long stretch while items keep coming.
   task automatic test_back_pressure();
      gaps_on  = 1'b0;
      hold_off = 1'b1;
      test_random_angles(60);
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (matrix_queue.size() == 0) begin
            $display("%0t: unexpected matrix, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            rsp_type want;
            want = matrix_queue.pop_front();
            for (int f = 0; f < 9; f++) begin
               if (want[16*f +: 16] !== rsp_data[16*f +: 16]) begin
                  $display("%0t: entry %0d expected %h actual %h", $time, 8 - f,
                           want[16*f +: 16], rsp_data[16*f +: 16]);
                  error_count++;
               end
            end
         end
      end
   end

   // Receiver: phases of full speed and random stalls, plus one long hold-off.
   initial begin
      int n;
      n = 0;
      forever begin
         @(posedge clock);
         n++;
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            hold_off = 1'b0;
         end
         if ((n / 64) % 3 == 0) rsp_ready <= 1'b1;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   initial begin
      #2000000;
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_angles();
      test_back_pressure();
      test_random_angles(340);
      while (matrix_queue.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
